// ===== sv/cfr_pkg.sv =====
`default_nettype none
package cfr_pkg;

   localparam int FRAME_BYTES = 64;
   localparam int PAY_LIMIT   = FRAME_BYTES - 9;
   localparam int POS_W       = $clog2(FRAME_BYTES + 1);
   localparam int PPOS_W      = $clog2(FRAME_BYTES);
   localparam int PAY_CNT_W   = $clog2(PAY_LIMIT + 1);

   localparam logic [23:0] IDENT_RESET = 24'h505752;

   localparam logic [1:0] REG_IDENT   = 2'd0;
   localparam logic [1:0] REG_CURRENT = 2'd1;
   localparam logic [1:0] REG_VOLTAGE = 2'd2;
   localparam logic [1:0] REG_POWER   = 2'd3;

   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_POINT   = 8'h2E;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] NUL        = 8'h00;

   typedef enum logic [3:0] {
      S_IDLE, S_HEAD, S_PONG, S_LABEL, S_DIV, S_DIGIT, S_POINT, S_TENTH,
      S_PCT, S_HEX_HI, S_HEX_LO, S_CR, S_LF
   } seq_state_type;

   function automatic logic [7:0] ping_char(input logic [2:0] k);
      case (k)
         3'd0: ping_char = "p";
         3'd1: ping_char = "i";
         3'd2: ping_char = "n";
         default: ping_char = "g";
      endcase
   endfunction

   function automatic logic [7:0] pong_char(input logic [1:0] k);
      case (k)
         2'd0: pong_char = "p";
         2'd1: pong_char = "o";
         2'd2: pong_char = "n";
         default: pong_char = "g";
      endcase
   endfunction

   function automatic logic [7:0] getdata_char(input logic [2:0] k);
      case (k)
         3'd0: getdata_char = "G";
         3'd1: getdata_char = "E";
         3'd2: getdata_char = "T";
         3'd3: getdata_char = "D";
         3'd4: getdata_char = "A";
         3'd5: getdata_char = "T";
         default: getdata_char = "A";
      endcase
   endfunction

   function automatic logic [7:0] label_char(input logic [1:0] v);
      case (v)
         2'd0: label_char = "I";
         2'd1: label_char = "U";
         default: label_char = "W";
      endcase
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) hex_char = CH_ZERO + {4'd0, n};
      else hex_char = 8'h37 + {4'd0, n};
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") nibble_of = 4'(c - "0");
      else if (c >= "A" && c <= "F") nibble_of = 4'(c - 8'h37);
      else if (c >= "a" && c <= "f") nibble_of = 4'(c - 8'h57);
      else nibble_of = 4'd0;
   endfunction

endpackage
`default_nettype wire

// ===== sv/command_frame_responder_unit.sv =====
// Command frame responder.
// The req channel carries received bytes, one per beat. Bytes collect into a
// frame that ends at a line feed; a byte arriving with a full frame held starts
// a new frame. Bytes are taken only while the block is idle.
// A valid ping or GETDATA frame starts a reply that leaves on the rsp channel,
// one byte per beat, with rsp_final_byte set on the closing line feed.
// While a reply is built req_stall stays high. A reply byte moves on only when
// the receiver does not stall; before each telemetry value is sent, one shared
// divide-by-ten unit peels off its decimal digits.
// An output register holds the current reply byte; when the receiver stalls,
// the sequencer waits and the byte holds.
// The csr port writes the address and telemetry registers.
// Synchronous reset clears the frame state and loads the register defaults.
`default_nettype none
module command_frame_responder_unit
   import cfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_final_byte,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   logic [23:0] ident_ff;
   logic [15:0] tele_ff [3];

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        rsum_ff, rsum_in;
   logic              pseen_ff, pseen_in;
   logic [PPOS_W-1:0] ppos_ff, ppos_in;
   logic [7:0]        hi_ff, hi_in, lo_ff, lo_in;
   logic [1:0]        bap_ff, bap_in;
   logic              hdr_ff, hdr_in, pz_ff, pz_in, ping_ff, ping_in, gd_ff, gd_in;
   logic              reply_start;

   seq_state_type     state_ff, state_in;
   logic [2:0]        step_ff, step_in;
   logic [1:0]        vsel_ff, vsel_in;
   logic [7:0]        sum_ff, sum_in;
   logic [PAY_CNT_W-1:0] pcnt_ff, pcnt_in;
   logic              isping_ff, isping_in;
   logic [15:0]       x_ff, x_in;
   logic [3:0]        dig_ff [5];
   logic              dig_we;
   logic [31:0]       prod;
   logic [12:0]       quo;
   logic [15:0]       rem;

   logic              out_load, out_final;
   logic [7:0]        out_byte;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_final_ff;

   logic              accept;

   assign req_stall      = (state_ff != S_IDLE);
   assign accept         = req_valid && !req_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tx_byte    = rsp_byte_ff;
   assign rsp_final_byte = rsp_final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_ff   <= IDENT_RESET;
         tele_ff[0] <= '0;
         tele_ff[1] <= '0;
         tele_ff[2] <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_IDENT:   ident_ff   <= csr_data;
            REG_CURRENT: tele_ff[0] <= csr_data[15:0];
            REG_VOLTAGE: tele_ff[1] <= csr_data[15:0];
            REG_POWER:   tele_ff[2] <= csr_data[15:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      logic              clr;
      logic [POS_W-1:0]  p;
      logic [5:0]        k;
      logic [7:0]        b;
      logic [7:0]        idb;
      logic              valid;
      clr = (pos_ff >= POS_W'(FRAME_BYTES));
      b   = req_rx_byte;
      p   = clr ? '0 : pos_ff;
      k   = 6'(p - POS_W'(4));
      rsum_in  = clr ? '0 : rsum_ff;
      pseen_in = clr ? 1'b0 : pseen_ff;
      ppos_in  = clr ? '0 : ppos_ff;
      hi_in    = clr ? '0 : hi_ff;
      lo_in    = clr ? '0 : lo_ff;
      bap_in   = clr ? '0 : bap_ff;
      hdr_in   = clr ? 1'b1 : hdr_ff;
      pz_in    = clr ? 1'b0 : pz_ff;
      ping_in  = clr ? 1'b1 : ping_ff;
      gd_in    = clr ? 1'b1 : gd_ff;
      idb = 8'd0;
      case (p)
         POS_W'(1): idb = ident_ff[23:16];
         POS_W'(2): idb = ident_ff[15:8];
         default:   idb = ident_ff[7:0];
      endcase
      if (p == '0 && b != CH_DOLLAR) hdr_in = 1'b0;
      if (p >= POS_W'(1) && p <= POS_W'(3) && b != idb) hdr_in = 1'b0;
      if (!pseen_in) begin
         rsum_in = rsum_in + b;
         if (b == CH_PERCENT) begin
            pseen_in = 1'b1;
            ppos_in  = PPOS_W'(p);
            if (p >= POS_W'(4) && !pz_in) begin
               if (k != 6'd4) ping_in = 1'b0;
               if (k != 6'd7) gd_in = 1'b0;
            end
         end else if (p >= POS_W'(4) && !pz_in) begin
            if (b == NUL) begin
               if (k != 6'd4) ping_in = 1'b0;
               if (k != 6'd7) gd_in = 1'b0;
               pz_in = 1'b1;
            end else begin
               if (k >= 6'd4 || b != ping_char(k[2:0])) ping_in = 1'b0;
               if (k >= 6'd7 || b != getdata_char(k[2:0])) gd_in = 1'b0;
            end
         end
      end else begin
         if (bap_in != 2'd3) bap_in = bap_in + 2'd1;
         if (bap_in == 2'd1) hi_in = b;
         else if (bap_in == 2'd2) lo_in = b;
      end
      pos_in = p + POS_W'(1);
      valid = pseen_in && ppos_in >= PPOS_W'(4) && bap_in >= 2'd2 && hdr_in &&
              rsum_in == {nibble_of(hi_in), nibble_of(lo_in)};
      reply_start = (b == CH_LF) && valid && (ping_in || gd_in);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_rx_byte == CH_LF)) begin
         pos_ff   <= '0;
         rsum_ff  <= '0;
         pseen_ff <= 1'b0;
         ppos_ff  <= '0;
         hi_ff    <= '0;
         lo_ff    <= '0;
         bap_ff   <= '0;
         hdr_ff   <= 1'b1;
         pz_ff    <= 1'b0;
         ping_ff  <= 1'b1;
         gd_ff    <= 1'b1;
      end else if (accept) begin
         pos_ff   <= pos_in;
         rsum_ff  <= rsum_in;
         pseen_ff <= pseen_in;
         ppos_ff  <= ppos_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
         bap_ff   <= bap_in;
         hdr_ff   <= hdr_in;
         pz_ff    <= pz_in;
         ping_ff  <= ping_in;
         gd_ff    <= gd_in;
      end
   end

   assign prod = 32'(x_ff) * 32'h0000CCCD;
   assign quo  = prod[31:19];
   assign rem  = x_ff - ({quo, 3'b000} + {2'b00, quo, 1'b0});

   always_comb begin
      logic [7:0] cur_byte;
      logic       has_out, cur_pay, cur_sum, pay_full, fire, out_free;
      cur_byte = 8'd0;
      has_out  = 1'b1;
      cur_pay  = 1'b0;
      cur_sum  = 1'b1;
      out_free = !rsp_valid_ff || !rsp_stall;
      pay_full = (pcnt_ff >= PAY_CNT_W'(PAY_LIMIT));
      state_in  = state_ff;
      step_in   = step_ff;
      vsel_in   = vsel_ff;
      sum_in    = sum_ff;
      pcnt_in   = pcnt_ff;
      isping_in = isping_ff;
      x_in      = x_ff;
      dig_we    = 1'b0;
      unique case (state_ff)
         S_IDLE:   has_out = 1'b0;
         S_HEAD: begin
            case (step_ff)
               3'd0:    cur_byte = CH_HASH;
               3'd1:    cur_byte = ident_ff[23:16];
               3'd2:    cur_byte = ident_ff[15:8];
               default: cur_byte = ident_ff[7:0];
            endcase
         end
         S_PONG: begin
            cur_byte = pong_char(step_ff[1:0]);
            cur_pay  = 1'b1;
         end
         S_LABEL: begin
            case (step_ff)
               3'd0:    cur_byte = CH_COMMA;
               3'd1:    cur_byte = label_char(vsel_ff);
               default: cur_byte = CH_COLON;
            endcase
            cur_pay = 1'b1;
         end
         S_DIV:    has_out = 1'b0;
         S_DIGIT: begin
            cur_byte = CH_ZERO + {4'd0, dig_ff[step_ff]};
            cur_pay  = 1'b1;
         end
         S_POINT: begin
            cur_byte = CH_POINT;
            cur_pay  = 1'b1;
         end
         S_TENTH: begin
            cur_byte = CH_ZERO + {4'd0, dig_ff[0]};
            cur_pay  = 1'b1;
         end
         S_PCT:    cur_byte = CH_PERCENT;
         S_HEX_HI: begin
            cur_byte = hex_char(sum_ff[7:4]);
            cur_sum  = 1'b0;
         end
         S_HEX_LO: begin
            cur_byte = hex_char(sum_ff[3:0]);
            cur_sum  = 1'b0;
         end
         S_CR: begin
            cur_byte = CH_CR;
            cur_sum  = 1'b0;
         end
         S_LF: begin
            cur_byte = CH_LF;
            cur_sum  = 1'b0;
         end
         default:  has_out = 1'b0;
      endcase
      fire      = !has_out || (cur_pay && pay_full) || out_free;
      out_load  = has_out && fire && !(cur_pay && pay_full);
      out_byte  = cur_byte;
      out_final = (state_ff == S_LF);
      if (out_load && cur_sum) sum_in = sum_ff + cur_byte;
      if (out_load && cur_pay) pcnt_in = pcnt_ff + PAY_CNT_W'(1);
      if (fire) begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept && reply_start) begin
                  state_in  = S_HEAD;
                  step_in   = 3'd0;
                  sum_in    = 8'd0;
                  pcnt_in   = '0;
                  isping_in = ping_in;
               end
            end
            S_HEAD: begin
               if (step_ff == 3'd3) begin
                  state_in = isping_ff ? S_PONG : S_LABEL;
                  step_in  = isping_ff ? 3'd0 : 3'd1;
                  vsel_in  = 2'd0;
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end
            S_PONG: begin
               if (step_ff == 3'd3) state_in = S_PCT;
               else step_in = step_ff + 3'd1;
            end
            S_LABEL: begin
               if (step_ff == 3'd2) begin
                  state_in = S_DIV;
                  step_in  = 3'd0;
                  x_in     = tele_ff[vsel_ff];
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end
            S_DIV: begin
               dig_we = 1'b1;
               x_in   = {3'b000, quo};
               if (step_ff == 3'd4) begin
                  state_in = S_DIGIT;
                  if (rem[3:0] != 4'd0) step_in = 3'd4;
                  else if (dig_ff[3] != 4'd0) step_in = 3'd3;
                  else if (dig_ff[2] != 4'd0) step_in = 3'd2;
                  else step_in = 3'd1;
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end
            S_DIGIT: begin
               if (step_ff == 3'd1) state_in = S_POINT;
               else step_in = step_ff - 3'd1;
            end
            S_POINT:  state_in = S_TENTH;
            S_TENTH: begin
               if (vsel_ff == 2'd2) begin
                  state_in = S_PCT;
               end else begin
                  vsel_in  = vsel_ff + 2'd1;
                  state_in = S_LABEL;
                  step_in  = 3'd0;
               end
            end
            S_PCT:    state_in = S_HEX_HI;
            S_HEX_HI: state_in = S_HEX_LO;
            S_HEX_LO: state_in = S_CR;
            S_CR:     state_in = S_LF;
            S_LF:     state_in = S_IDLE;
            default:  state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      vsel_ff   <= vsel_in;
      sum_ff    <= sum_in;
      pcnt_ff   <= pcnt_in;
      isping_ff <= isping_in;
      x_ff      <= x_in;
      if (dig_we) dig_ff[step_ff] <= rem[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_byte_ff  <= out_byte;
         rsp_final_ff <= out_final;
      end
   end

endmodule
`default_nettype wire

// ===== sv/cfr_checker.sv =====
`default_nettype none
module cfr_checker
   import cfr_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_tx_byte,
   input wire logic        rsp_final_byte
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx_byte) &&
      $stable(rsp_final_byte))
      else $error("stalled reply beat changed");

   a_final_is_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_byte |-> rsp_tx_byte == CH_LF)
      else $error("final beat is not a line feed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("reply beat right after reset");

   a_busy_in_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_byte |-> req_stall)
      else $error("input taken in the middle of a reply");

endmodule

bind command_frame_responder_unit cfr_checker u_cfr_checker (.*);
`default_nettype wire
